### hw/rtl/imwt_pkg.sv
// types and constants shared by the motion trigger block
package imwt_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [31:0]        sample_time;
    } sample_item_t;

    typedef struct packed {
        logic        candidate;
        logic [31:0] max_accel_sq;
        logic [31:0] max_gyro_sq;
        logic [31:0] window_first_time;
        logic [31:0] window_last_time;
    } result_item_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int THR_W       = 15;
    localparam int STRIDE_W    = 16;
    localparam int SQ_W        = 31;
    localparam int MAG_W       = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GYRO_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EVAL_STRIDE     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EVALUATE_ENABLE = 2'd3;

    localparam logic [THR_W-1:0]    ACCEL_THRESHOLD_RST = 15'd29491;
    localparam logic [THR_W-1:0]    GYRO_THRESHOLD_RST  = 15'd820;
    localparam logic [STRIDE_W-1:0] EVAL_STRIDE_RST     = 16'd100;

endpackage

### hw/rtl/imu_window_motion_trigger.sv
// top level: sliding window peak magnitude motion trigger
//
// sample channel: one six-axis item (accel, gyro, timestamp) per handshake
// result channel: zero or one item per sample, with candidate flag, both peak
//   squared magnitudes and the oldest and newest timestamps of the window
// cfg channel: index and data, always ready, to be written only while the
// block is idle; the block itself does not enforce this
// every sample is written into a ring of WINDOW entries held in one
// synchronous memory. an item that does not trigger an evaluation is taken
// without a stall. once the ring is full, the stride count is reached and
// evaluation is enabled, the block walks the memory one entry a cycle
// through a read / square / max pipeline, so sample_ready stays low from the
// acceptance of an evaluating item until the walk ends and the result is
// loaded; the result appears at the same edge at which sample_ready rises.
// the one-entry-a-cycle memory read sets the length of the walk.
// the result sits in an output register: new samples are taken while it
// waits, and a walk that finishes while it is still held stalls until
// result_ready takes it.
// reset sets only pointers, counters, state, configuration and result_valid
// to defaults; the ring is not cleared, as no entry is read before it fills.
module imu_window_motion_trigger
    import imwt_pkg::*;
#(
    parameter int WINDOW = 100
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  sample_item_t           sample,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_item_t           result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // configuration registers
    logic [THR_W-1:0]    accel_thr_reg;
    logic [THR_W-1:0]    gyro_thr_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic                enable_reg;
    logic [2*THR_W-1:0]  accel_thr_sq_reg;
    logic [2*THR_W-1:0]  gyro_thr_sq_reg;

    // ring state
    sample_item_t        ring_mem [WINDOW];
    logic [AW-1:0]       wp_reg;
    logic [AW-1:0]       wp_next;
    logic                full_reg;
    logic                full_next;
    logic [STRIDE_W-1:0] since_reg;
    logic [STRIDE_W-1:0] since_inc;

    // walk control
    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [AW-1:0]       rd_addr_reg;
    logic [CW-1:0]       iss_cnt_reg;
    logic                issue;
    logic                v1_reg;
    logic                v2_reg;
    logic                first1_reg;
    sample_item_t        rd_data_reg;

    // square and max datapath
    logic signed [31:0]  prod [6];
    logic [SQ_W-1:0]     sq_reg [6];
    logic [MAG_W-1:0]    accel_mag;
    logic [MAG_W-1:0]    gyro_mag;
    logic [MAG_W-1:0]    max_accel_reg;
    logic [MAG_W-1:0]    max_gyro_reg;
    logic [31:0]         first_time_reg;
    logic [31:0]         last_time_reg;

    logic                accept;
    logic                due;
    logic                start_walk;
    logic                load_result;
    logic                candidate;
    result_item_t        result_reg;
    logic                result_valid_reg;

    assign cfg_ready    = 1'b1;
    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;

    // ring pointer and counters after this sample
    assign wp_next   = (wp_reg == AW'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
    assign full_next = full_reg || (wp_reg == AW'(WINDOW - 1));
    assign since_inc = (since_reg == '1) ? since_reg : since_reg + 1'b1;
    assign due        = full_next && (since_inc >= stride_reg);
    assign start_walk = accept && due && enable_reg;

    assign issue = (state_reg == ST_WALK) && (iss_cnt_reg != CW'(WINDOW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_thr_reg <= ACCEL_THRESHOLD_RST;
            gyro_thr_reg  <= GYRO_THRESHOLD_RST;
            stride_reg    <= EVAL_STRIDE_RST;
            enable_reg    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ACCEL_THRESHOLD: accel_thr_reg <= cfg_data[THR_W-1:0];
                CFG_GYRO_THRESHOLD:  gyro_thr_reg  <= cfg_data[THR_W-1:0];
                CFG_EVAL_STRIDE:     stride_reg    <= cfg_data[STRIDE_W-1:0];
                CFG_EVALUATE_ENABLE: enable_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // thresholds squared, settled long before any walk ends
    always_ff @(posedge clk)
    begin
        accel_thr_sq_reg <= (2*THR_W)'(accel_thr_reg) * (2*THR_W)'(accel_thr_reg);
        gyro_thr_sq_reg  <= (2*THR_W)'(gyro_thr_reg) * (2*THR_W)'(gyro_thr_reg);
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[wp_reg] <= sample;
        end
        if (issue)
        begin
            rd_data_reg <= ring_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            full_reg  <= 1'b0;
            since_reg <= '0;
        end
        else if (accept)
        begin
            wp_reg    <= wp_next;
            full_reg  <= full_next;
            since_reg <= due ? '0 : since_inc;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        load_result = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_walk)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!issue && !v1_reg && !v2_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    load_result = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_addr_reg <= '0;
            iss_cnt_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            first1_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            v1_reg     <= issue;
            v2_reg     <= v1_reg;
            first1_reg <= issue && (iss_cnt_reg == '0);
            if (start_walk)
            begin
                // oldest entry sits where the next write will land
                rd_addr_reg <= wp_next;
                iss_cnt_reg <= '0;
            end
            else if (issue)
            begin
                rd_addr_reg <= (rd_addr_reg == AW'(WINDOW - 1)) ? '0 : rd_addr_reg + 1'b1;
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
            end
        end
    end

    // stage 1: six squares of the entry just read
    always_comb
    begin
        prod[0] = 32'(rd_data_reg.accel_x) * 32'(rd_data_reg.accel_x);
        prod[1] = 32'(rd_data_reg.accel_y) * 32'(rd_data_reg.accel_y);
        prod[2] = 32'(rd_data_reg.accel_z) * 32'(rd_data_reg.accel_z);
        prod[3] = 32'(rd_data_reg.gyro_x) * 32'(rd_data_reg.gyro_x);
        prod[4] = 32'(rd_data_reg.gyro_y) * 32'(rd_data_reg.gyro_y);
        prod[5] = 32'(rd_data_reg.gyro_z) * 32'(rd_data_reg.gyro_z);
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            for (int k = 0; k < 6; k++)
            begin
                sq_reg[k] <= prod[k][SQ_W-1:0];
            end
        end
        if (v1_reg && first1_reg)
        begin
            first_time_reg <= rd_data_reg.sample_time;
        end
        if (accept)
        begin
            last_time_reg <= sample.sample_time;
        end
    end

    // stage 2: sum of squares and running peak
    assign accel_mag = MAG_W'(sq_reg[0]) + MAG_W'(sq_reg[1]) + MAG_W'(sq_reg[2]);
    assign gyro_mag  = MAG_W'(sq_reg[3]) + MAG_W'(sq_reg[4]) + MAG_W'(sq_reg[5]);

    always_ff @(posedge clk)
    begin
        if (start_walk)
        begin
            max_accel_reg <= '0;
            max_gyro_reg  <= '0;
        end
        else if (v2_reg)
        begin
            if (accel_mag > max_accel_reg)
            begin
                max_accel_reg <= accel_mag;
            end
            if (gyro_mag > max_gyro_reg)
            begin
                max_gyro_reg <= gyro_mag;
            end
        end
    end

    assign candidate = (max_accel_reg > MAG_W'(accel_thr_sq_reg))
                    || (max_gyro_reg > MAG_W'(gyro_thr_sq_reg));

    // output register
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg.candidate         <= candidate;
            result_reg.max_accel_sq      <= max_accel_reg;
            result_reg.max_gyro_sq       <= max_gyro_reg;
            result_reg.window_first_time <= first_time_reg;
            result_reg.window_last_time  <= last_time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    // a walk only runs over a full ring
    a_walk_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> full_reg)
        else $error("walk started before the ring was full");

    // the read pipeline never issues more than one pass over the ring
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        iss_cnt_reg <= CW'(WINDOW))
        else $error("walk issued past the ring depth");

    // a finished walk waits while the held result is stalled
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && result_valid && !result_ready
        |=> (state_reg == ST_DONE))
        else $error("result lost while output was stalled");

    // a new result only comes out of the done state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");
`endif

endmodule
